// File: src/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types and constants of the voxel face culling mesher: action and
// register codes, face codes, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    // Input actions
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_START = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [1:0] CFG_SCALE  = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int SIZE_W     = 6;
    localparam int POS_W      = 5;
    localparam int COORD_W    = 21;
    localparam int VTX_W      = 16;
    localparam int FACES      = 6;
    localparam int FACE_W     = 3;

    localparam logic [SIZE_W-1:0]     SIZE_RST  = 6'd32;
    localparam logic [CFG_DATA_W-1:0] SCALE_RST = 16'd256;
    localparam logic [VTX_W-1:0]      VTX_STEP  = 16'd4;

    // Face order: back (-z), front (+z), bottom (-y), top (+y), left (-x), right (+x)
    localparam int FACE_BACK   = 0;
    localparam int FACE_FRONT  = 1;
    localparam int FACE_BOTTOM = 2;
    localparam int FACE_TOP    = 3;
    localparam int FACE_LEFT   = 4;
    localparam int FACE_RIGHT  = 5;

    // Row read selector: center row, z-1, z+1, y-1, y+1
    typedef enum logic [2:0] {
        RD_CTR = 3'd0,
        RD_ZM  = 3'd1,
        RD_ZP  = 3'd2,
        RD_YM  = 3'd3,
        RD_YP  = 3'd4
    } t_rd_sel;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_WR_RD  = 3'd2,
        ST_WR_WB  = 3'd3,
        ST_Q_RD   = 3'd4,
        ST_Q_WAIT = 3'd5,
        ST_Q_EMIT = 3'd6
    } t_state;

    typedef struct packed {
        logic    latch;        // capture input word
        logic    vc_clear;     // vertex counter to zero
        logic    sweep_init;   // restart clearing sweep
        logic    sweep_write;  // write zero row, advance sweep
        logic    rd_en;        // read one occupancy row
        t_rd_sel rd_sel;
        logic    wb;           // write back modified row
        logic    emit;         // load output register with next face
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;    // input position inside used extent
        logic sweep_done;  // sweep at last row
        logic pending;     // visible faces remain
        logic out_free;    // output register can load
        logic last_pick;   // face being picked is the last one
    } t_dp_sts;

endpackage

// File: src/vfcm_ram.sv
// ----------------------------------------------------------------------------
// vfcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vfcm_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: src/vfcm_ctrl.sv
// ----------------------------------------------------------------------------
// vfcm_ctrl
// Controller: sequences clearing sweep, voxel read-modify-write, the five
// row reads of a query and the emission of visible faces.
// ----------------------------------------------------------------------------
module vfcm_ctrl
    import vfcm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    input  t_dp_sts    i_sts,
    output logic       o_stall,
    output t_dp_cmd    o_cmd
);

    t_state  r_state, n_state;
    t_rd_sel r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_step  <= RD_CTR;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_CTR;
        o_stall = (r_state != ST_IDLE);

        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep_write = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_action)
                        ACT_CLEAR: begin
                            o_cmd.vc_clear   = 1'b1;
                            o_cmd.sweep_init = 1'b1;
                            n_state          = ST_CLEAR;
                        end
                        ACT_WRITE: begin
                            if (i_sts.in_range) begin
                                n_state = ST_WR_RD;
                            end
                        end
                        ACT_START: begin
                            o_cmd.vc_clear = 1'b1;
                        end
                        ACT_QUERY: begin
                            if (i_sts.in_range) begin
                                n_state = ST_Q_RD;
                                n_step  = RD_CTR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CTR;
                n_state      = ST_WR_WB;
            end
            ST_WR_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_Q_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = r_step;
                unique case (r_step)
                    RD_CTR:  n_step = RD_ZM;
                    RD_ZM:   n_step = RD_ZP;
                    RD_ZP:   n_step = RD_YM;
                    RD_YM:   n_step = RD_YP;
                    RD_YP:   n_state = ST_Q_WAIT;
                    default: n_state = ST_Q_WAIT;
                endcase
            end
            ST_Q_WAIT: begin
                // last row lands in the datapath this cycle
                n_state = ST_Q_EMIT;
            end
            ST_Q_EMIT: begin
                if (!i_sts.pending) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_pick) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: src/vfcm_dp.sv
// ----------------------------------------------------------------------------
// vfcm_dp
// Datapath: configuration registers, occupancy row memory, neighbor
// capture, face picking, scaled coordinates, vertex counter and the
// output register.
// ----------------------------------------------------------------------------
module vfcm_dp
    import vfcm_pkg::*;
#(
    parameter int GRID_DIM = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [POS_W-1:0]      i_pos_z,
    input  logic                  i_solid,
    input  logic                  i_stall,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_valid,
    output logic [FACE_W-1:0]     o_face_code,
    output logic [VTX_W-1:0]      o_base_vertex,
    output logic [COORD_W-1:0]    o_min_x,
    output logic [COORD_W-1:0]    o_min_y,
    output logic [COORD_W-1:0]    o_min_z,
    output logic [COORD_W-1:0]    o_max_x,
    output logic [COORD_W-1:0]    o_max_y,
    output logic [COORD_W-1:0]    o_max_z,
    output logic                  o_last_face
);

    localparam int ROWS = GRID_DIM * GRID_DIM;
    localparam int AW   = $clog2(ROWS);
    localparam int XW   = $clog2(GRID_DIM);
    localparam int EW   = 7;

    function automatic logic [EW-1:0] used_ext(input logic [SIZE_W-1:0] s);
        logic [EW-1:0] se;
        se = EW'(s);
        return (se > EW'(GRID_DIM)) ? EW'(GRID_DIM) : se;
    endfunction

    // Configuration
    logic [SIZE_W-1:0]     r_size_x, r_size_y, r_size_z;
    logic [CFG_DATA_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RST;
            r_size_y <= SIZE_RST;
            r_size_z <= SIZE_RST;
            r_scale  <= SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE_X: r_size_x <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y: r_size_y <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z: r_size_z <= i_cfg_data[SIZE_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [EW-1:0] ex, ey, ez;
    logic [EW-1:0] px, py, pz;
    logic [FACES-1:0] in_edge;

    assign ex = used_ext(r_size_x);
    assign ey = used_ext(r_size_y);
    assign ez = used_ext(r_size_z);
    assign px = EW'(i_pos_x);
    assign py = EW'(i_pos_y);
    assign pz = EW'(i_pos_z);

    assign in_edge[FACE_BACK]   = (pz == '0);
    assign in_edge[FACE_FRONT]  = (pz + EW'(1) >= ez);
    assign in_edge[FACE_BOTTOM] = (py == '0);
    assign in_edge[FACE_TOP]    = (py + EW'(1) >= ey);
    assign in_edge[FACE_LEFT]   = (px == '0);
    assign in_edge[FACE_RIGHT]  = (px + EW'(1) >= ex);

    // Latched query / write word
    logic [POS_W-1:0]   r_x, r_y, r_z;
    logic               r_wsolid;
    logic [FACES-1:0]   r_edge;
    logic [COORD_W-1:0] r_min_x, r_min_y, r_min_z;
    logic [COORD_W-1:0] r_max_x, r_max_y, r_max_z;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_x      <= i_pos_x;
            r_y      <= i_pos_y;
            r_z      <= i_pos_z;
            r_wsolid <= i_solid;
            r_edge   <= in_edge;
            r_min_x  <= COORD_W'(i_pos_x) * COORD_W'(r_scale);
            r_min_y  <= COORD_W'(i_pos_y) * COORD_W'(r_scale);
            r_min_z  <= COORD_W'(i_pos_z) * COORD_W'(r_scale);
        end
        if (i_cmd.rd_en) begin
            r_max_x <= r_min_x + COORD_W'(r_scale);
            r_max_y <= r_min_y + COORD_W'(r_scale);
            r_max_z <= r_min_z + COORD_W'(r_scale);
        end
    end

    // Row addressing: one row holds all x of a (y, z) pair
    logic [AW-1:0] addr_c, raddr, waddr;
    logic [XW-1:0] xi, xm, xp;

    assign addr_c = AW'(int'(r_z) * GRID_DIM + int'(r_y));
    assign xi     = XW'(r_x);
    assign xm     = r_edge[FACE_LEFT]  ? xi : XW'(xi - XW'(1));
    assign xp     = r_edge[FACE_RIGHT] ? xi : XW'(xi + XW'(1));

    always_comb begin
        raddr = addr_c;
        unique case (i_cmd.rd_sel)
            RD_CTR: raddr = addr_c;
            RD_ZM:  if (!r_edge[FACE_BACK])   raddr = AW'(addr_c - AW'(GRID_DIM));
            RD_ZP:  if (!r_edge[FACE_FRONT])  raddr = AW'(addr_c + AW'(GRID_DIM));
            RD_YM:  if (!r_edge[FACE_BOTTOM]) raddr = AW'(addr_c - AW'(1));
            RD_YP:  if (!r_edge[FACE_TOP])    raddr = AW'(addr_c + AW'(1));
            default: raddr = addr_c;
        endcase
    end

    // Clearing sweep
    logic [AW-1:0] r_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sweep_init) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_write) begin
            r_sweep <= AW'(r_sweep + AW'(1));
        end
    end

    // Occupancy memory
    logic [GRID_DIM-1:0] rdata, wrow, wdata;
    logic                we;

    always_comb begin
        wrow     = rdata;
        wrow[xi] = r_wsolid;
    end

    assign we    = i_cmd.sweep_write | i_cmd.wb;
    assign waddr = i_cmd.sweep_write ? r_sweep : addr_c;
    assign wdata = i_cmd.sweep_write ? '0 : wrow;

    vfcm_ram #(
        .DATA_W (GRID_DIM),
        .DEPTH  (ROWS)
    ) u_occ (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Neighbor capture, one read behind the request
    logic             r_cap_en;
    t_rd_sel          r_cap_sel;
    logic             r_center;
    logic [FACES-1:0] r_open;
    logic [FACES-1:0] pick;
    logic [FACE_W-1:0] pick_code;

    always_comb begin
        pick      = r_open & FACES'(~r_open + FACES'(1));
        pick_code = '0;
        for (int i = 0; i < FACES; i++) begin
            if (pick[i]) pick_code = FACE_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en  <= 1'b0;
            r_cap_sel <= RD_CTR;
            r_center  <= 1'b0;
            r_open    <= '0;
        end else begin
            r_cap_en  <= i_cmd.rd_en;
            r_cap_sel <= i_cmd.rd_sel;
            if (r_cap_en) begin
                unique case (r_cap_sel)
                    RD_CTR: begin
                        r_center           <= rdata[xi];
                        r_open[FACE_LEFT]  <= r_edge[FACE_LEFT]  | ~rdata[xm];
                        r_open[FACE_RIGHT] <= r_edge[FACE_RIGHT] | ~rdata[xp];
                    end
                    RD_ZM:  r_open[FACE_BACK]   <= r_edge[FACE_BACK]   | ~rdata[xi];
                    RD_ZP:  r_open[FACE_FRONT]  <= r_edge[FACE_FRONT]  | ~rdata[xi];
                    RD_YM:  r_open[FACE_BOTTOM] <= r_edge[FACE_BOTTOM] | ~rdata[xi];
                    RD_YP:  r_open[FACE_TOP]    <= r_edge[FACE_TOP]    | ~rdata[xi];
                    default: ;
                endcase
            end else if (i_cmd.emit) begin
                r_open <= r_open & ~pick;
            end
        end
    end

    // Vertex counter
    logic [VTX_W-1:0] r_vc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.vc_clear) begin
            r_vc <= '0;
        end else if (i_cmd.emit) begin
            r_vc <= r_vc + VTX_STEP;
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_face_code   <= pick_code;
            o_base_vertex <= r_vc;
            o_min_x       <= r_min_x;
            o_min_y       <= r_min_y;
            o_min_z       <= r_min_z;
            o_max_x       <= r_max_x;
            o_max_y       <= r_max_y;
            o_max_z       <= r_max_z;
            o_last_face   <= ((r_open & ~pick) == '0);
        end
    end

    assign o_valid = r_out_valid;

    assign o_sts.in_range   = (px < ex) && (py < ey) && (pz < ez);
    assign o_sts.sweep_done = (r_sweep == AW'(ROWS - 1));
    assign o_sts.pending    = r_center && (r_open != '0);
    assign o_sts.out_free   = !r_out_valid || !i_stall;
    assign o_sts.last_pick  = ((r_open & ~pick) == '0);

endmodule

// File: src/voxel_face_culling_mesher.sv
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher
// Occupancy grid of GRID_DIM^3 voxels with visible-face extraction: clear,
// write, start mesh and query actions; a query on a solid voxel returns
// one word per face that borders air or the edge of the used extent.
//
//   channel   direction  handshake           payload
//   -------   ---------  ------------------  ---------------------------------
//   input     in         i_valid / o_stall   action, pos_x/y/z, solid
//   output    out        o_valid / i_stall   face_code, base_vertex, min/max
//                                            x/y/z, last_face
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// Memory: the grid is stored as GRID_DIM*GRID_DIM rows of GRID_DIM bits in
// one single-port-read RAM, and that read port sets the pace. A query steps
// through accept, five row reads for center, z-1, z+1, y-1, y+1, and the
// capture of the last row, then emits one word per visible face, or none
// when the voxel is air or has no visible face; a write steps through
// accept, row read and row write back; start mesh and ignored words are
// handled on acceptance alone.
// Reset and clear: both sweep the memory one row a cycle, all
// GRID_DIM*GRID_DIM rows (1024 at the default size), with o_stall high throughout.
// Stalls: results sit in an output register; while it is stalled, face
// emission holds. The last face loads that register and the block returns
// to accept the next word while it still waits to be taken.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher
    import vfcm_pkg::*;
#(
    parameter int GRID_DIM = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_action,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [POS_W-1:0]      i_pos_z,
    input  logic                  i_solid,
    // result words
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FACE_W-1:0]     o_face_code,
    output logic [VTX_W-1:0]      o_base_vertex,
    output logic [COORD_W-1:0]    o_min_x,
    output logic [COORD_W-1:0]    o_min_y,
    output logic [COORD_W-1:0]    o_min_z,
    output logic [COORD_W-1:0]    o_max_x,
    output logic [COORD_W-1:0]    o_max_y,
    output logic [COORD_W-1:0]    o_max_z,
    output logic                  o_last_face
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: decode accepted word, step through reads and emission
    vfcm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_sts    (sts),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // Datapath: grid memory, neighbor flags, coordinates, output register
    vfcm_dp #(
        .GRID_DIM (GRID_DIM)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_solid       (i_solid),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_face_code   (o_face_code),
        .o_base_vertex (o_base_vertex),
        .o_min_x       (o_min_x),
        .o_min_y       (o_min_y),
        .o_min_z       (o_min_z),
        .o_max_x       (o_max_x),
        .o_max_y       (o_max_y),
        .o_max_z       (o_max_z),
        .o_last_face   (o_last_face)
    );

endmodule

// File: tb/tb_voxel_face_culling_mesher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_face_culling_mesher
// Self-checking bench for the voxel face culling mesher. A directed table
// covers an empty grid, lone voxels at both corners, neighbor culling,
// start mesh, air writes, clipped, saturated and empty extents, extreme
// scale and clear. Random phases follow: clustered writes and queries
// with some noise, under several extents and scales and three idling
// patterns. Every result word is checked field by field against an
// in-bench model of the grid and the vertex counter.
// ----------------------------------------------------------------------------
module tb_voxel_face_culling_mesher
    import vfcm_pkg::*;
();

    localparam int GRID_DIM        = 32;
    localparam int CELLS           = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int SETTLE_CYC      = 1100;   // a clear sweeps 1024 rows and returns no word
    localparam int TAIL_CYC        = 64;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int WORDS_PER_PHASE = 48;

    localparam logic [FACES-1:0] ALL_FACES = '1;
    localparam logic [FACES-1:0] NO_FACES  = '0;

    // One visible face as the block returns it
    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [VTX_W-1:0]   vtx;
        logic [COORD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
        logic               last;
    } t_face_word;

    // One row of the directed table: an input word or a register write
    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_action               act;
        logic [POS_W-1:0]      x, y, z;
        logic                  solid;
        logic                  typed;   // face mask below is typed in, not predicted
        logic [FACES-1:0]      mask;
        logic [1:0]            reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    t_action               i_action;
    logic [POS_W-1:0]      i_pos_x;
    logic [POS_W-1:0]      i_pos_y;
    logic [POS_W-1:0]      i_pos_z;
    logic                  i_solid;
    logic                  o_valid;
    logic                  i_stall;
    logic [FACE_W-1:0]     o_face_code;
    logic [VTX_W-1:0]      o_base_vertex;
    logic [COORD_W-1:0]    o_min_x;
    logic [COORD_W-1:0]    o_min_y;
    logic [COORD_W-1:0]    o_min_z;
    logic [COORD_W-1:0]    o_max_x;
    logic [COORD_W-1:0]    o_max_y;
    logic [COORD_W-1:0]    o_max_z;
    logic                  o_last_face;

    voxel_face_culling_mesher #(
        .GRID_DIM(GRID_DIM)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_solid       (i_solid),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_face_code   (o_face_code),
        .o_base_vertex (o_base_vertex),
        .o_min_x       (o_min_x),
        .o_min_y       (o_min_y),
        .o_min_z       (o_min_z),
        .o_max_x       (o_max_x),
        .o_max_y       (o_max_y),
        .o_max_z       (o_max_z),
        .o_last_face   (o_last_face)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Grid model: occupancy, vertex counter and register mirror
    // ------------------------------------------------------------------------
    bit                    voxel_grid [CELLS];
    logic [VTX_W-1:0]      vertex_count = '0;
    logic [SIZE_W-1:0]     extent_reg [3] = '{SIZE_RST, SIZE_RST, SIZE_RST};
    logic [CFG_DATA_W-1:0] scale_reg = SCALE_RST;

    t_face_word            faces_due [$];   // expected face words, oldest first
    t_stim_row             directed_rows [$];
    int                    error_count    = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    cycle_count    = 0;

    // Extents above the grid saturate to it
    function automatic int used_extent(logic [SIZE_W-1:0] s);
        return (s > GRID_DIM) ? GRID_DIM : int'(s);
    endfunction

    function automatic int cell_of(int x, int y, int z);
        return (z * GRID_DIM + y) * GRID_DIM + x;
    endfunction

    function automatic bit in_extent(int x, int y, int z);
        return x < used_extent(extent_reg[CFG_SIZE_X]) &&
               y < used_extent(extent_reg[CFG_SIZE_Y]) &&
               z < used_extent(extent_reg[CFG_SIZE_Z]);
    endfunction

    // A face is open when its neighbor is air or past the extent; a voxel
    // that is air or outside the extent shows nothing
    function automatic logic [FACES-1:0] open_faces(int x, int y, int z);
        logic [FACES-1:0] m;
        int ex, ey, ez;
        ex = used_extent(extent_reg[CFG_SIZE_X]);
        ey = used_extent(extent_reg[CFG_SIZE_Y]);
        ez = used_extent(extent_reg[CFG_SIZE_Z]);
        m  = NO_FACES;
        if (in_extent(x, y, z) && voxel_grid[cell_of(x, y, z)]) begin
            m[FACE_BACK]   = (z == 0)      ? 1'b1 : !voxel_grid[cell_of(x, y, z - 1)];
            m[FACE_FRONT]  = (z + 1 >= ez) ? 1'b1 : !voxel_grid[cell_of(x, y, z + 1)];
            m[FACE_BOTTOM] = (y == 0)      ? 1'b1 : !voxel_grid[cell_of(x, y - 1, z)];
            m[FACE_TOP]    = (y + 1 >= ey) ? 1'b1 : !voxel_grid[cell_of(x, y + 1, z)];
            m[FACE_LEFT]   = (x == 0)      ? 1'b1 : !voxel_grid[cell_of(x - 1, y, z)];
            m[FACE_RIGHT]  = (x + 1 >= ex) ? 1'b1 : !voxel_grid[cell_of(x + 1, y, z)];
        end
        return m;
    endfunction

    // Advance the model by one accepted word and queue the faces it returns
    function automatic void mesh_word(t_action act, int x, int y, int z, logic solid,
                                      logic typed, logic [FACES-1:0] typed_mask);
        logic [FACES-1:0] faces;
        t_face_word       w;
        int               remaining, sc, f;
        case (act)
            ACT_CLEAR: begin
                foreach (voxel_grid[i]) voxel_grid[i] = 1'b0;
                vertex_count = '0;
            end
            ACT_START: vertex_count = '0;
            ACT_WRITE: begin
                if (in_extent(x, y, z)) voxel_grid[cell_of(x, y, z)] = solid;
            end
            default: begin
                faces     = typed ? typed_mask : open_faces(x, y, z);
                remaining = $countones(faces);
                sc        = int'(scale_reg);
                for (f = 0; f < FACES; f++) begin
                    if (faces[f]) begin
                        remaining--;
                        w.face  = FACE_W'(f);
                        w.vtx   = vertex_count;
                        w.min_x = COORD_W'(x * sc);
                        w.min_y = COORD_W'(y * sc);
                        w.min_z = COORD_W'(z * sc);
                        w.max_x = COORD_W'((x + 1) * sc);
                        w.max_y = COORD_W'((y + 1) * sc);
                        w.max_z = COORD_W'((z + 1) * sc);
                        w.last  = (remaining == 0);
                        faces_due = {faces_due, w};
                        vertex_count += VTX_STEP;
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall at the falling edge, check at the rising edge
    // ------------------------------------------------------------------------
    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_face_word();
        t_face_word want;
        if (faces_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual face %0d base %0d", $time,
                     o_face_code, o_base_vertex);
            error_count++;
        end else begin
            want = faces_due.pop_front();
            compare_field("face_code",   want.face,  o_face_code);
            compare_field("base_vertex", want.vtx,   o_base_vertex);
            compare_field("min_x",       want.min_x, o_min_x);
            compare_field("min_y",       want.min_y, o_min_y);
            compare_field("min_z",       want.min_z, o_min_z);
            compare_field("max_x",       want.max_x, o_max_x);
            compare_field("max_y",       want.max_y, o_max_y);
            compare_field("max_z",       want.max_z, o_max_z);
            compare_field("last_face",   want.last,  o_last_face);
        end
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < recv_stall_pct);
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) check_face_word();
        end
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Drive one word at the falling edge, hold it until accepted, then predict
    task automatic send_word(t_action act, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [POS_W-1:0] z, logic solid, logic typed,
                             logic [FACES-1:0] typed_mask);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_pos_x  <= x;
        i_pos_y  <= y;
        i_pos_z  <= z;
        i_solid  <= solid;
        do @(posedge i_clk); while (o_stall);
        mesh_word(act, x, y, z, solid, typed, typed_mask);
    endtask

    // Drop valid and wait for every expected face word to come back
    task automatic hold_off();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (faces_due.size() != 0) @(posedge i_clk);
    endtask

    // Let a clear or write that returns no word finish before touching registers
    task automatic settle();
        hold_off();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z: extent_reg[idx] = SIZE_W'(val);
            default:                            scale_reg       = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    function automatic void add_word(t_action act, int x, int y, int z, logic solid,
                                     logic typed, logic [FACES-1:0] mask);
        t_stim_row r;
        r         = '0;
        r.kind    = ROW_WORD;
        r.act     = act;
        r.x       = POS_W'(x);
        r.y       = POS_W'(y);
        r.z       = POS_W'(z);
        r.solid   = solid;
        r.typed   = typed;
        r.mask    = mask;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_reg(logic [1:0] idx, int val);
        t_stim_row r;
        r         = '0;
        r.kind    = ROW_REG;
        r.act     = ACT_START;
        r.reg_idx = idx;
        r.reg_val = CFG_DATA_W'(val);
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void build_directed();
        // empty grid after reset, then lone voxels at both corners
        add_word(ACT_QUERY, 0, 0, 0, 1'b0, 1'b1, NO_FACES);
        add_word(ACT_WRITE, 0, 0, 0, 1'b1, 1'b0, NO_FACES);
        add_word(ACT_QUERY, 0, 0, 0, 1'b0, 1'b1, ALL_FACES);
        add_word(ACT_WRITE, 31, 31, 31, 1'b1, 1'b0, NO_FACES);
        add_word(ACT_QUERY, 31, 31, 31, 1'b0, 1'b1, ALL_FACES);
        // neighbors on +x, +y, +z hide front, top and right of the origin
        add_word(ACT_WRITE, 1, 0, 0, 1'b1, 1'b0, NO_FACES);
        add_word(ACT_WRITE, 0, 1, 0, 1'b1, 1'b0, NO_FACES);
        add_word(ACT_WRITE, 0, 0, 1, 1'b1, 1'b0, NO_FACES);
        add_word(ACT_QUERY, 0, 0, 0, 1'b0, 1'b1,
                 FACES'((1 << FACE_BACK) | (1 << FACE_BOTTOM) | (1 << FACE_LEFT)));
        add_word(ACT_QUERY, 1, 0, 0, 1'b0, 1'b0, NO_FACES);
        // start mesh restarts the vertex numbering
        add_word(ACT_START, 7, 19, 25, 1'b1, 1'b0, NO_FACES);
        add_word(ACT_QUERY, 0, 0, 1, 1'b0, 1'b0, NO_FACES);
        // writing air over a solid voxel
        add_word(ACT_WRITE, 0, 0, 0, 1'b0, 1'b0, NO_FACES);
        add_word(ACT_QUERY, 0, 0, 0, 1'b0, 1'b1, NO_FACES);
        // clipped extent, z saturates, full-scale voxels
        add_reg(CFG_SIZE_X, 2);
        add_reg(CFG_SIZE_Y, 1);
        add_reg(CFG_SIZE_Z, 33);
        add_reg(CFG_SCALE, 65535);
        add_word(ACT_QUERY, 1, 0, 0, 1'b0, 1'b0, NO_FACES);
        add_word(ACT_QUERY, 0, 1, 0, 1'b0, 1'b1, NO_FACES);   // solid but past y extent
        add_word(ACT_WRITE, 5, 0, 0, 1'b1, 1'b0, NO_FACES);   // past x extent, dropped
        // x saturates: the dropped write must not show up
        add_reg(CFG_SIZE_X, 63);
        add_word(ACT_QUERY, 5, 0, 0, 1'b0, 1'b1, NO_FACES);
        add_word(ACT_WRITE, 31, 0, 31, 1'b1, 1'b0, NO_FACES);
        add_word(ACT_QUERY, 31, 0, 31, 1'b0, 1'b0, NO_FACES);  // largest coordinates
        // empty extent hides everything
        add_reg(CFG_SIZE_X, 0);
        add_word(ACT_WRITE, 0, 0, 0, 1'b1, 1'b0, NO_FACES);
        add_word(ACT_QUERY, 1, 0, 0, 1'b0, 1'b1, NO_FACES);
        add_word(ACT_CLEAR, 31, 31, 31, 1'b1, 1'b0, NO_FACES);
        // back to defaults: the clear emptied the grid
        add_reg(CFG_SIZE_X, 32);
        add_reg(CFG_SIZE_Y, 32);
        add_reg(CFG_SIZE_Z, 32);
        add_reg(CFG_SCALE, 256);
        add_word(ACT_QUERY, 31, 31, 31, 1'b0, 1'b1, NO_FACES);
        add_word(ACT_QUERY, 1, 0, 0, 1'b0, 1'b1, NO_FACES);
    endfunction

    task automatic run_directed();
        t_stim_row r;
        t_row_kind prev_kind;
        prev_kind = ROW_WORD;
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.kind == ROW_REG) begin
                if (prev_kind == ROW_WORD) settle();
                write_reg(r.reg_idx, r.reg_val);
            end else begin
                send_word(r.act, r.x, r.y, r.z, r.solid, r.typed, r.mask);
            end
            prev_kind = r.kind;
        end
    endtask

    // ------------------------------------------------------------------------
    // Random phases
    // ------------------------------------------------------------------------

    // Step to a neighbor of the cluster center; may land one past the extent
    function automatic int near_coord(int c);
        int v;
        v = c + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > GRID_DIM - 1) v = GRID_DIM - 1;
        return v;
    endfunction

    function automatic int center_coord(int e);
        return (e > 1) ? int'($urandom_range(e - 1)) : 0;
    endfunction

    task automatic run_random_phase(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                                    logic [SIZE_W-1:0] sz, logic [CFG_DATA_W-1:0] scale);
        int cx, cy, cz, pick, n;
        settle();
        write_reg(CFG_SIZE_X, CFG_DATA_W'(sx));
        write_reg(CFG_SIZE_Y, CFG_DATA_W'(sy));
        write_reg(CFG_SIZE_Z, CFG_DATA_W'(sz));
        write_reg(CFG_SCALE, scale);
        cx = 0;
        cy = 0;
        cz = 0;
        for (n = 0; n < WORDS_PER_PHASE; n++) begin
            // pause the sender until the block has drained
            if (n % 24 == 23) hold_off();
            // build small clusters so that neighbors actually hide faces
            if (n == 0 || $urandom_range(9) == 0) begin
                cx = center_coord(used_extent(sx));
                cy = center_coord(used_extent(sy));
                cz = center_coord(used_extent(sz));
            end
            pick = $urandom_range(99);
            if (pick < 2) begin
                send_word(ACT_CLEAR, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                          1'($urandom), 1'b0, NO_FACES);
            end else if (pick < 7) begin
                send_word(ACT_START, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                          1'($urandom), 1'b0, NO_FACES);
            end else if (pick < 12) begin
                send_word($urandom_range(1) ? ACT_WRITE : ACT_QUERY, POS_W'($urandom),
                          POS_W'($urandom), POS_W'($urandom), 1'($urandom), 1'b0, NO_FACES);
            end else if (pick < 56) begin
                send_word(ACT_WRITE, POS_W'(near_coord(cx)), POS_W'(near_coord(cy)),
                          POS_W'(near_coord(cz)), ($urandom_range(99) < 75), 1'b0, NO_FACES);
            end else begin
                send_word(ACT_QUERY, POS_W'(near_coord(cx)), POS_W'(near_coord(cy)),
                          POS_W'(near_coord(cz)), 1'($urandom), 1'b0, NO_FACES);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_SIZE_X;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_action   = ACT_CLEAR;
        i_pos_x    = '0;
        i_pos_y    = '0;
        i_pos_z    = '0;
        i_solid    = 1'b0;
        build_directed();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the clearing sweep that follows reset
        do @(posedge i_clk); while (o_stall);

        send_idle_pct  = 13;
        recv_stall_pct = 84;
        run_directed();

        // sender dense / receiver busy, then swapped, then no idling at all
        run_random_phase(6'd4, 6'd4, 6'd4, 16'd256);
        run_random_phase(6'd3, 6'd2, 6'd5, 16'($urandom));
        send_idle_pct  = 84;
        recv_stall_pct = 13;
        run_random_phase(6'd32, 6'd32, 6'd32, 16'hFFFF);
        run_random_phase(6'd1, 6'd1, 6'd1, 16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_phase(6'd63, 6'd40, 6'd2, 16'($urandom));
        run_random_phase(6'd6, 6'd6, 6'd6, 16'($urandom));

        hold_off();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (error_count == 0 && faces_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
